// File: src/lsp_pkg.sv
`default_nettype none
package lsp_pkg;

	// Fixed widths of the item fields
	localparam int MODE_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;
	localparam int CAP_W    = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Data word returned for a peek outside the stored range
	localparam logic signed [VALUE_W-1:0] BAD_PEEK_WORD = -32'sd1;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH   = 3'd0,
		MODE_POP    = 3'd1,
		MODE_PEEK   = 3'd2,
		MODE_TOP    = 3'd3,
		MODE_BOTTOM = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_OVERFLOW  = 3'd1,
		STAT_UNDERFLOW = 3'd2,
		STAT_BAD_POS   = 3'd3,
		STAT_EMPTY     = 3'd4
	} status_t;

	// Per-cycle commands broadcast to every cell of the chain
	typedef struct packed {
		logic push;   // take the word of the cell above
		logic pop;    // take the word of the cell below
		logic load;   // copy own word into the read lane
		logic shift;  // take the read lane of the cell below
	} cell_ctrl_t;

endpackage
`default_nettype wire

// File: src/lsp_cell.sv
`default_nettype none
module lsp_cell
	import lsp_pkg::*;
#(
	parameter int WORD_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire cell_ctrl_t            ctrl,
	input  wire logic [WORD_WIDTH-1:0] above_word,
	input  wire logic [WORD_WIDTH-1:0] below_word,
	input  wire logic [WORD_WIDTH-1:0] below_lane,
	output logic      [WORD_WIDTH-1:0] word,
	output logic      [WORD_WIDTH-1:0] lane
);

	logic [WORD_WIDTH-1:0] word_q;
	logic [WORD_WIDTH-1:0] lane_q;

	// Stored word: shift down on push, up on pop
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			word_q <= above_word;
		end else if (ctrl.pop) begin
			word_q <= below_word;
		end
	end

	// Read lane: snapshot the word, then walk toward the top cell
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			lane_q <= word_q;
		end else if (ctrl.shift) begin
			lane_q <= below_lane;
		end
	end

	assign word = word_q;
	assign lane = lane_q;

endmodule
`default_nettype wire

// File: src/lifo_stack_with_peek_unit.sv
`default_nettype none
// LIFO stack of signed words built as a chain of cells; cell 0 holds the top.
// Input channel: in_valid / in_stall with mode, push_value and position; an
// item is taken at a clock edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with data_word, status, is_full,
// is_empty and entry_count; exactly one result item per input item, in order.
// Capacity: cfg_we writes cfg_wdata into the capacity register (0 acts as 1,
// values above DEPTH act as DEPTH); write it only while the block is idle.
// Results: push, pop, top read and every refused request enter the output
// register at the accepting edge; the next item may follow at once.
// A peek at position p or a bottom read on a stack of n entries walks the
// read lane through the cells one cell per cycle until the word reaches
// cell 0; it enters the output register once that register is free, and
// in_stall stays high for the whole walk.
// Stall: the result waits in the output register while out_stall is high;
// the block takes a new item only when that register is free or being
// emptied at the same edge.
// Reset: the stack is empty and the capacity reads 16. Cell words are not
// cleared; they are only read below the entry count.
module lifo_stack_with_peek_unit
	import lsp_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic        [MODE_W-1:0]   mode,
	input  wire logic signed [VALUE_W-1:0]  push_value,
	input  wire logic        [POS_W-1:0]    position,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed      [VALUE_W-1:0]  data_word,
	output logic             [STATUS_W-1:0] status,
	output logic                            is_full,
	output logic                            is_empty,
	output logic             [COUNT_W-1:0]  entry_count,
	input  wire logic                       cfg_we,
	input  wire logic        [CAP_W-1:0]    cfg_wdata
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t                    state_q;
	logic [IDX_W-1:0]          walk_q;
	logic [CNT_W-1:0]          count_q;
	logic [CAP_W-1:0]          cap_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] data_q;
	status_t                   status_q;
	logic                      full_q;
	logic                      empty_q;
	logic [COUNT_W-1:0]        count_out_q;

	// Chain wiring
	logic [WORD_WIDTH-1:0] cell_word [DEPTH];
	logic [WORD_WIDTH-1:0] cell_lane [DEPTH];
	logic signed [WORD_WIDTH-1:0] store_word;
	logic signed [WORD_WIDTH-1:0] top_word;
	logic signed [WORD_WIDTH-1:0] lane_word;
	cell_ctrl_t            ctrl;

	// Request decode
	logic                      accept;
	logic                      out_free;
	logic                      res_load;
	logic [CNT_W-1:0]          eff_cap;
	logic                      full_now;
	logic                      empty_now;
	logic                      pos_ok;
	logic                      do_push;
	logic                      do_pop;
	logic                      do_walk;
	logic [IDX_W-1:0]          walk_target;
	logic signed [VALUE_W-1:0] res_data;
	status_t                   res_status;
	logic [CNT_W-1:0]          count_next;

	assign store_word = WORD_WIDTH'(push_value);
	assign top_word   = cell_word[0];
	assign lane_word  = cell_lane[0];

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	// A new result enters the output register at this edge
	assign res_load = ((state_q == ST_IDLE) && accept && !do_walk) ||
		((state_q == ST_WALK) && (walk_q == '0) && out_free);

	// Clamp the capacity register into 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (int'(cap_q) > DEPTH) begin
			eff_cap = CNT_W'(DEPTH);
		end else begin
			eff_cap = CNT_W'(cap_q);
		end
	end

	assign full_now  = count_q >= eff_cap;
	assign empty_now = count_q == '0;
	assign pos_ok    = (position != '0) && (int'(position) <= int'(count_q));

	always_comb begin
		do_push     = 1'b0;
		do_pop      = 1'b0;
		do_walk     = 1'b0;
		walk_target = '0;
		res_data    = '0;
		res_status  = STAT_OK;
		case (mode_t'(mode))
			MODE_PUSH: begin
				if (full_now) begin
					res_status = STAT_OVERFLOW;
				end else begin
					do_push = 1'b1;
				end
			end
			MODE_POP: begin
				if (empty_now) begin
					res_status = STAT_UNDERFLOW;
				end else begin
					do_pop   = 1'b1;
					res_data = VALUE_W'(top_word);
				end
			end
			MODE_PEEK: begin
				if (!pos_ok) begin
					res_data   = BAD_PEEK_WORD;
					res_status = STAT_BAD_POS;
				end else begin
					do_walk     = 1'b1;
					walk_target = IDX_W'(int'(position) - 1);
				end
			end
			MODE_TOP: begin
				if (empty_now) begin
					res_status = STAT_EMPTY;
				end else begin
					res_data = VALUE_W'(top_word);
				end
			end
			MODE_BOTTOM: begin
				if (empty_now) begin
					res_status = STAT_EMPTY;
				end else begin
					do_walk     = 1'b1;
					walk_target = IDX_W'(int'(count_q) - 1);
				end
			end
			default: begin
				res_status = STAT_OK;
			end
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (do_push) begin
			count_next = count_q + 1'b1;
		end else if (do_pop) begin
			count_next = count_q - 1'b1;
		end
	end

	// Commands to the chain
	always_comb begin
		ctrl.push  = accept && do_push;
		ctrl.pop   = accept && do_pop;
		ctrl.load  = accept && do_walk;
		ctrl.shift = (state_q == ST_WALK) && (walk_q != '0);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] above_w;
		logic [WORD_WIDTH-1:0] below_w;
		logic [WORD_WIDTH-1:0] below_l;

		if (i == 0) begin : g_head
			assign above_w = store_word;
		end else begin : g_mid
			assign above_w = cell_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign below_w = '0;
			assign below_l = '0;
		end else begin : g_body
			assign below_w = cell_word[i+1];
			assign below_l = cell_lane[i+1];
		end

		lsp_cell #(
			.WORD_WIDTH(WORD_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.above_word (above_w),
			.below_word (below_w),
			.below_lane (below_l),
			.word       (cell_word[i]),
			.lane       (cell_lane[i])
		);
	end

	// Sequencer, count, capacity register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			walk_q      <= '0;
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
			data_q      <= '0;
			status_q    <= STAT_OK;
			full_q      <= 1'b0;
			empty_q     <= 1'b1;
			count_out_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			// Drop the result once the receiver takes it
			if (out_valid_q && !out_stall && !res_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= count_next;
						if (do_walk) begin
							state_q <= ST_WALK;
							walk_q  <= walk_target;
						end else begin
							out_valid_q <= 1'b1;
							data_q      <= res_data;
							status_q    <= res_status;
							full_q      <= count_next >= eff_cap;
							empty_q     <= count_next == '0;
							count_out_q <= COUNT_W'(count_next);
						end
					end
				end
				ST_WALK: begin
					if (walk_q != '0) begin
						walk_q <= walk_q - 1'b1;
					end else if (out_free) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						data_q      <= VALUE_W'(lane_word);
						status_q    <= STAT_OK;
						full_q      <= full_now;
						empty_q     <= empty_now;
						count_out_q <= COUNT_W'(count_q);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign data_word   = data_q;
	assign status      = status_q;
	assign is_full     = full_q;
	assign is_empty    = empty_q;
	assign entry_count = count_out_q;

	// No new item while the lane walks
	a_walk_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> in_stall)
		else $error("input taken during lane walk");

	// A taken push grows the stack by one
	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not advance the count");

	// The lane walk counts down without leaving the walk
	a_walk_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) && (walk_q != '0) |=>
		(state_q == ST_WALK) && (walk_q == $past(walk_q) - 1'b1))
		else $error("lane walk did not advance");

	// A result appears only after an accept or at the end of a walk
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(accept) || $past(state_q == ST_WALK))
		else $error("result without a request");

	// The stack never holds more than the chain has cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accept && do_push |-> int'(count_q) < DEPTH)
		else $error("push beyond the last cell");

endmodule
`default_nettype wire

// File: tb/tb_lifo_stack_with_peek_unit.sv
`timescale 1ns / 1ps

module tb_lifo_stack_with_peek_unit;
	import lsp_pkg::*;

	localparam int STACK_DEPTH     = 16;
	localparam int ITEMS_PER_PHASE = 68;
	localparam int NUM_PHASES      = 10;
	// Long output hold-off used to back the stack up into its input
	localparam int HOLD_CYCLES     = 120;
	// Nothing accepted for this many cycles means the block is hung
	localparam int WATCHDOG_LIMIT  = 3000;
	// Bottom reads walk up to STACK_DEPTH cells, so allow that and some slack
	localparam int TAIL_CYCLES     = STACK_DEPTH + 8;

	// Mode codes the block does not define; they must be ignored
	localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [MODE_W-1:0]         op;
		logic signed [VALUE_W-1:0] word;
		logic [POS_W-1:0]          pos;
	} stack_req_t;

	typedef struct {
		logic signed [VALUE_W-1:0] data;
		logic [STATUS_W-1:0]       stat;
		logic                      full;
		logic                      empty;
		logic [COUNT_W-1:0]        count;
	} stack_resp_t;

	// Shadow stack: tracks the words, the fill level and the capacity register,
	// and queues the response each accepted request must produce.
	class stack_scoreboard;
		logic signed [VALUE_W-1:0] words [STACK_DEPTH];
		int unsigned               held;
		logic [CAP_W-1:0]          cap_reg;
		stack_resp_t               awaited [$];
		int unsigned               mismatches;
		int unsigned               checked;
		int unsigned               op_seen [8];
		int unsigned               stat_seen [8];

		function new();
			held = 0;
			cap_reg = CAP_RESET;
			mismatches = 0;
			checked = 0;
			foreach (op_seen[i]) op_seen[i] = 0;
			foreach (stat_seen[i]) stat_seen[i] = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] v);
			cap_reg = v;
		endfunction

		function int unsigned usable_slots();
			if (cap_reg == 0) return 1;
			if (cap_reg > STACK_DEPTH) return STACK_DEPTH;
			return cap_reg;
		endfunction

		function void note_request(logic [MODE_W-1:0] m, logic signed [VALUE_W-1:0] v,
				logic [POS_W-1:0] p);
			stack_resp_t r;
			int unsigned lim;
			lim = usable_slots();
			r.data = '0;
			r.stat = STAT_OK;
			op_seen[m]++;
			case (mode_t'(m))
				MODE_PUSH: begin
					if (held >= lim) r.stat = STAT_OVERFLOW;
					else begin
						words[held] = v;
						held++;
					end
				end
				MODE_POP: begin
					if (held == 0) r.stat = STAT_UNDERFLOW;
					else begin
						held--;
						r.data = words[held];
					end
				end
				MODE_PEEK: begin
					if (p == 0 || p > held) begin
						r.data = BAD_PEEK_WORD;
						r.stat = STAT_BAD_POS;
					end else r.data = words[held - p];
				end
				MODE_TOP: begin
					if (held == 0) r.stat = STAT_EMPTY;
					else r.data = words[held - 1];
				end
				MODE_BOTTOM: begin
					if (held == 0) r.stat = STAT_EMPTY;
					else r.data = words[0];
				end
				default: ;
			endcase
			r.full  = (held >= lim);
			r.empty = (held == 0);
			r.count = held[COUNT_W-1:0];
			awaited.push_back(r);
		endfunction

		function void check_result(logic signed [VALUE_W-1:0] d, logic [STATUS_W-1:0] s,
				logic f, logic e, logic [COUNT_W-1:0] c);
			stack_resp_t want;
			checked++;
			if (awaited.size() == 0) begin
				$error("result with nothing pending: data_word %0d status %0d", d, s);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			stat_seen[want.stat]++;
			if (d !== want.data) begin
				$error("data_word: expected %0d, actual %0d", want.data, d);
				mismatches++;
			end
			if (s !== want.stat) begin
				$error("status: expected %0d, actual %0d", want.stat, s);
				mismatches++;
			end
			if (f !== want.full) begin
				$error("is_full: expected %0b, actual %0b", want.full, f);
				mismatches++;
			end
			if (e !== want.empty) begin
				$error("is_empty: expected %0b, actual %0b", want.empty, e);
				mismatches++;
			end
			if (c !== want.count) begin
				$error("entry_count: expected %0d, actual %0d", want.count, c);
				mismatches++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [MODE_W-1:0]          mode;
	logic signed [VALUE_W-1:0]  push_value;
	logic [POS_W-1:0]           position;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [VALUE_W-1:0]  data_word;
	logic [STATUS_W-1:0]        status;
	logic                       is_full;
	logic                       is_empty;
	logic [COUNT_W-1:0]         entry_count;
	logic                       cfg_we;
	logic [CAP_W-1:0]           cfg_wdata;

	stack_scoreboard sb;

	// Pacing controls shared between the stimulus and the output consumer
	bit          in_quiet;
	bit          out_quiet;
	bit          long_hold_req;
	int unsigned idle_cycles;
	int unsigned cap_writes;
	// Generator-side estimate of the fill level, used only to aim peeks
	int unsigned gen_count;
	int unsigned cur_cap;

	lifo_stack_with_peek_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.push_value  (push_value),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_word   (data_word),
		.status      (status),
		.is_full     (is_full),
		.is_empty    (is_empty),
		.entry_count (entry_count),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample both channels at the rising edge. Check the result first: a request
	// taken at this edge cannot have its result at the same edge.
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (out_valid && !out_stall)
				sb.check_result(data_word, status, is_full, is_empty, entry_count);
			if (in_valid && !in_stall)
				sb.note_request(mode, push_value, position);
			if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles, %0d results pending",
					idle_cycles, sb.awaited.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Output consumer: draw a stall length per result, then take the result.
	// On request, hold off for a long stretch so the stack backs up.
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) n = HOLD_CYCLES;
			else n = out_quiet ? 0 : $urandom_range(16);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				long_hold_req = 1'b0;
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	function automatic int unsigned slots_for(logic [CAP_W-1:0] v);
		if (v == 0) return 1;
		if (v > STACK_DEPTH) return STACK_DEPTH;
		return v;
	endfunction

	// Offer one request after a random gap and hold it until it is taken.
	// Valid stays high on return; stop_input drops it when the stream pauses.
	task automatic send_item(input stack_req_t req);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(16);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= req.op;
		push_value <= req.word;
		position   <= req.pos;
		do @(posedge clk); while (in_stall);
		if (req.op == MODE_PUSH && gen_count < cur_cap) gen_count++;
		else if (req.op == MODE_POP && gen_count > 0) gen_count--;
	endtask

	task automatic send(input logic [MODE_W-1:0] m, input logic signed [VALUE_W-1:0] v,
			input logic [POS_W-1:0] p);
		stack_req_t req;
		req.op = m;
		req.word = v;
		req.pos = p;
		send_item(req);
	endtask

	task automatic stop_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Hold the sender until every outstanding result has been consumed
	task automatic drain_all();
		stop_input();
		while (sb.awaited.size() != 0) @(posedge clk);
	endtask

	// Write the capacity register; only call with the block idle
	task automatic write_capacity(input logic [CAP_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(v);
		cur_cap = slots_for(v);
		cap_writes++;
	endtask

	// Draw a mostly well-formed request: pushes and pops with random words,
	// peeks aimed inside the stored range, top and bottom reads, and a slice of raw noise.
	function automatic stack_req_t pick_request(int push_pct);
		stack_req_t r;
		int roll;
		int sel;
		roll   = $urandom_range(99);
		r.word = $urandom;
		r.pos  = POS_W'($urandom_range(31));
		if (roll < 8) r.op = MODE_W'($urandom_range(7));
		else if (roll < 8 + push_pct) r.op = MODE_PUSH;
		else if (roll < 80) r.op = MODE_POP;
		else begin
			sel = $urandom_range(3);
			if (sel < 2) begin
				r.op = MODE_PEEK;
				if (gen_count > 0) r.pos = POS_W'($urandom_range(gen_count, 1));
			end else if (sel == 2) r.op = MODE_TOP;
			else r.op = MODE_BOTTOM;
		end
		return r;
	endfunction

	function automatic logic [CAP_W-1:0] capacity_for_phase(int ph);
		case (ph)
			0: return 5'd1;
			1: return 5'd16;
			2: return 5'd31;
			3: return 5'd3;
			4: return 5'd0;
			5: return 5'd8;
			6: return 5'd2;
			7: return 5'd17;
			default: return CAP_W'($urandom_range(31));
		endcase
	endfunction

	initial begin
		stack_req_t req;
		sb            = new();
		in_quiet      = 1'b0;
		out_quiet     = 1'b0;
		long_hold_req = 1'b0;
		idle_cycles   = 0;
		cap_writes    = 0;
		gen_count     = 0;
		cur_cap       = STACK_DEPTH;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		mode          = MODE_PUSH;
		push_value    = '0;
		position      = '0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;

		// Hold reset, then release it away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty stack: every read and the pop must refuse
		send(MODE_POP, 32'sd0, 5'd0);
		send(MODE_TOP, 32'sd0, 5'd0);
		send(MODE_BOTTOM, 32'sd0, 5'd0);
		send(MODE_PEEK, 32'sd0, 5'd1);
		send(MODE_SPARE_7, -32'sd1, 5'd31);
		// Push the word extremes, then read with peeks in and out of range, top and bottom
		send(MODE_PUSH, 32'sh7FFF_FFFF, 5'd0);
		send(MODE_PUSH, 32'sh8000_0000, 5'd31);
		send(MODE_PUSH, -32'sd1, 5'd0);
		send(MODE_PUSH, 32'sd0, 5'd0);
		send(MODE_PEEK, 32'sd0, 5'd0);
		send(MODE_PEEK, 32'sd0, 5'd4);
		send(MODE_PEEK, 32'sd0, 5'd5);
		send(MODE_PEEK, 32'sd0, 5'd31);
		send(MODE_TOP, 32'sd0, 5'd0);
		send(MODE_BOTTOM, 32'sd0, 5'd0);
		send(MODE_SPARE_5, 32'sh5555_5555, 5'd2);
		send(MODE_SPARE_6, 32'shAAAA_AAAA, 5'd3);
		// Capacity zero acts as one and sits below the fill level: push refused
		drain_all();
		write_capacity(5'd0);
		send(MODE_PUSH, 32'sh1234_5678, 5'd0);
		send(MODE_POP, 32'sd0, 5'd0);
		send(MODE_PEEK, 32'sd0, 5'd3);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_all();
			write_capacity(capacity_for_phase(ph));
			in_quiet  = (ph % 3 == 1);
			out_quiet = (ph % 3 == 2);
			if (ph == 1) begin
				// Back the block up: stop taking results while sending mostly pushes with no gap
				long_hold_req = 1'b1;
				in_quiet = 1'b1;
				repeat (24) begin
					req = pick_request(60);
					send_item(req);
				end
				in_quiet = 1'b0;
			end
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// In phase 5, pause the sender once mid-phase until every outstanding result is consumed
				if (ph == 5 && k == ITEMS_PER_PHASE / 2) drain_all();
				// Fill in the first half of a phase, empty in the second
				req = pick_request(k < ITEMS_PER_PHASE / 2 ? 50 : 20);
				send_item(req);
			end
		end

		drain_all();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d capacity settings; %0d results checked, %0d mismatches.",
			cap_writes, sb.checked, sb.mismatches);
		$display("push %0d pop %0d peek %0d top %0d bottom %0d; overflow %0d underflow %0d",
			sb.op_seen[MODE_PUSH], sb.op_seen[MODE_POP], sb.op_seen[MODE_PEEK],
			sb.op_seen[MODE_TOP], sb.op_seen[MODE_BOTTOM],
			sb.stat_seen[STAT_OVERFLOW], sb.stat_seen[STAT_UNDERFLOW]);
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
src/lsp_pkg.sv
src/lsp_cell.sv
src/lifo_stack_with_peek_unit.sv
tb/tb_lifo_stack_with_peek_unit.sv
